@@ design/bmrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmrm_pkg: shared types and codes for the byte memory register machine
// Opcodes, status codes, field widths and the queued instruction record.
// ----------------------------------------------------------------------------
package bmrm_pkg;

	localparam int OPC_W    = 3;
	localparam int REG_W    = 4;
	localparam int OFF_W    = 12;
	localparam int CNT_W    = 4;
	localparam int DATA_W   = 64;
	localparam int ABYTES_W = 13;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 13;
	localparam int BYTE_W   = 8;
	localparam int LANES    = 8;
	localparam int LANE_W   = 3;

	localparam logic [OPC_W-1:0] OP_NOP       = 3'd0;
	localparam logic [OPC_W-1:0] OP_ALLOC     = 3'd1;
	localparam logic [OPC_W-1:0] OP_STORE_IMM = 3'd2;
	localparam logic [OPC_W-1:0] OP_STORE_REG = 3'd3;
	localparam logic [OPC_W-1:0] OP_LOAD      = 3'd4;
	localparam logic [OPC_W-1:0] OP_ADD       = 3'd5;
	localparam logic [OPC_W-1:0] OP_SUB       = 3'd6;
	localparam logic [OPC_W-1:0] OP_PRINT     = 3'd7;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRINTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BOUNDS  = 2'd3;

	localparam logic [CNT_W-1:0] MAX_BYTES = 4'd8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [OPC_W-1:0]    op;
		logic [REG_W-1:0]    rd;
		logic [REG_W-1:0]    ra;
		logic [REG_W-1:0]    rb;
		logic [OFF_W-1:0]    off;
		logic [CNT_W-1:0]    cnt;
		logic [DATA_W-1:0]   imm;
		logic [ABYTES_W-1:0] abytes;
		logic                bad;
	} item_t;

endpackage

@@ design/bmrm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmrm_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bmrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bmrm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmrm_front: instruction intake and classification
// Checks register indexes and access size per opcode, then queues the
// instruction for the execution pipeline.
// ----------------------------------------------------------------------------
module bmrm_front #(
	parameter int NUM_REGS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bmrm_pkg::OPC_W-1:0]      opcode,
	input  logic [bmrm_pkg::REG_W-1:0]      dest_reg,
	input  logic [bmrm_pkg::REG_W-1:0]      src_reg_a,
	input  logic [bmrm_pkg::REG_W-1:0]      src_reg_b,
	input  logic [bmrm_pkg::OFF_W-1:0]      byte_offset,
	input  logic [bmrm_pkg::CNT_W-1:0]      byte_count,
	input  logic signed [bmrm_pkg::DATA_W-1:0] immediate,
	input  logic [bmrm_pkg::ABYTES_W-1:0]   alloc_bytes,
	output logic                            head_valid,
	output bmrm_pkg::item_t                 head,
	input  logic                            pop
);

	import bmrm_pkg::*;

	function automatic logic reg_ok(input logic [REG_W-1:0] r);
		return 32'(r) < 32'(NUM_REGS);
	endfunction

	logic  rd_ok, ra_ok, rb_ok, reg_bad, size_bad;
	item_t new_item;

	item_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push, do_pop;

	// classify
	always_comb begin
		rd_ok = reg_ok(dest_reg);
		ra_ok = reg_ok(src_reg_a);
		rb_ok = reg_ok(src_reg_b);
		case (opcode)
			OP_STORE_REG: begin
				reg_bad = !ra_ok;
			end
			OP_LOAD, OP_PRINT: begin
				reg_bad = !rd_ok;
			end
			OP_ADD, OP_SUB: begin
				reg_bad = !(rd_ok && ra_ok && rb_ok);
			end
			default: begin
				reg_bad = 1'b0;
			end
		endcase
		size_bad = (opcode inside {OP_STORE_IMM, OP_STORE_REG, OP_LOAD}) &&
			(byte_count > MAX_BYTES);

		new_item.op     = opcode;
		new_item.rd     = dest_reg;
		new_item.ra     = src_reg_a;
		new_item.rb     = src_reg_b;
		new_item.off    = byte_offset;
		new_item.cnt    = byte_count;
		new_item.imm    = immediate;
		new_item.abytes = alloc_bytes;
		new_item.bad    = reg_bad || size_bad;
	end

	// queue
	assign in_stall   = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];
	assign push       = in_valid && !in_stall;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

@@ design/bmrm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmrm_back: execution pipeline
// s1 takes forwarded operands, checks bounds, adds or subtracts, writes or
// reads the eight byte banks and applies alloc. s2 gathers loaded bytes and
// writes the register file. A result register holds the outgoing beat.
// ----------------------------------------------------------------------------
module bmrm_back #(
	parameter int MEM_BYTES = 4096,
	parameter int NUM_REGS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  bmrm_pkg::item_t                    head,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bmrm_pkg::STATUS_W-1:0]      status,
	output logic signed [bmrm_pkg::DATA_W-1:0] print_value
);

	import bmrm_pkg::*;

	localparam int RA_W    = $clog2(NUM_REGS);
	localparam int ROWS    = (MEM_BYTES + LANES - 1) / LANES;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int LIM_CAP = (MEM_BYTES > (2 ** LIMIT_W) - 1) ? (2 ** LIMIT_W) - 1 : MEM_BYTES;

	function automatic logic [RA_W-1:0] ridx(input logic [REG_W-1:0] r);
		logic [31:0] w;
		w = 32'(r);
		return w[RA_W-1:0];
	endfunction

	logic adv;

	// stage registers
	logic                valid_s1;
	item_t               item_s1;
	logic                valid_s2;
	logic [OPC_W-1:0]    op_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [DATA_W-1:0]   pval_s2;
	logic [DATA_W-1:0]   alu_s2;
	logic                wr_s2;
	logic [RA_W-1:0]     rd_s2;
	logic [LANE_W-1:0]   lane0_s2;
	logic [CNT_W-1:0]    cnt_s2;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   print_value_q;

	logic [LIMIT_W-1:0]  limit_q;
	logic [NUM_REGS-1:0] reg_valid_q;
	logic                lw_en_q;
	logic [RA_W-1:0]     lw_addr_q;
	logic [DATA_W-1:0]   lw_data_q;

	// register file ports
	logic [RA_W-1:0]   rf_raddr_a, rf_raddr_b, addr_a_s1, addr_b_s1;
	logic [DATA_W-1:0] rf_rdata_a, rf_rdata_b, rf_wdata;
	logic              rf_we;

	// s1 datapath
	logic [DATA_W-1:0]   a_val, b_val, store_v, alu_val, pval_val;
	logic [LIMIT_W-1:0]  end_addr;
	logic                is_mem, is_store, oob, ok;
	logic [STATUS_W-1:0] status_val;
	logic                mem_re;

	// byte banks
	logic [LANES-1:0]  bank_we;
	logic [BYTE_W-1:0] bank_wdata [LANES];
	logic [BYTE_W-1:0] bank_rdata [LANES];
	logic [ROW_W-1:0]  bank_row   [LANES];
	logic [DATA_W-1:0] ld_val;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv;

	// register reads issue as the head enters s1
	assign rf_raddr_a = (head.op == OP_PRINT) ? ridx(head.rd) : ridx(head.ra);
	assign rf_raddr_b = ridx(head.rb);
	assign addr_a_s1  = (item_s1.op == OP_PRINT) ? ridx(item_s1.rd) : ridx(item_s1.ra);
	assign addr_b_s1  = ridx(item_s1.rb);

	assign rf_we    = adv && valid_s2 && wr_s2;
	assign rf_wdata = (op_s2 == OP_LOAD) ? ld_val : alu_s2;

	bmrm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s2),
		.wdata (rf_wdata),
		.re    (adv),
		.raddr (rf_raddr_a),
		.rdata (rf_rdata_a)
	);

	bmrm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s2),
		.wdata (rf_wdata),
		.re    (adv),
		.raddr (rf_raddr_b),
		.rdata (rf_rdata_b)
	);

	// operand forwarding: pending s2 write first, then the write that
	// raced the read, then the array; never-written registers read zero
	always_comb begin
		if (valid_s2 && wr_s2 && (rd_s2 == addr_a_s1)) begin
			a_val = rf_wdata;
		end else if (lw_en_q && (lw_addr_q == addr_a_s1)) begin
			a_val = lw_data_q;
		end else if (reg_valid_q[addr_a_s1]) begin
			a_val = rf_rdata_a;
		end else begin
			a_val = '0;
		end

		if (valid_s2 && wr_s2 && (rd_s2 == addr_b_s1)) begin
			b_val = rf_wdata;
		end else if (lw_en_q && (lw_addr_q == addr_b_s1)) begin
			b_val = lw_data_q;
		end else if (reg_valid_q[addr_b_s1]) begin
			b_val = rf_rdata_b;
		end else begin
			b_val = '0;
		end
	end

	always_comb begin
		is_mem   = item_s1.op inside {OP_STORE_IMM, OP_STORE_REG, OP_LOAD};
		is_store = item_s1.op inside {OP_STORE_IMM, OP_STORE_REG};
		end_addr = LIMIT_W'(item_s1.off) + LIMIT_W'(item_s1.cnt);
		oob      = end_addr > limit_q;

		if (item_s1.bad) begin
			status_val = ST_BAD;
		end else if (is_mem && oob) begin
			status_val = ST_BOUNDS;
		end else if (item_s1.op == OP_PRINT) begin
			status_val = ST_PRINTED;
		end else begin
			status_val = ST_DONE;
		end
		ok = !item_s1.bad && !(is_mem && oob);

		store_v  = (item_s1.op == OP_STORE_IMM) ? item_s1.imm : a_val;
		alu_val  = (item_s1.op == OP_SUB) ? (a_val - b_val) : (a_val + b_val);
		pval_val = (status_val == ST_PRINTED) ? a_val : '0;
		mem_re   = adv && valid_s1 && (item_s1.op == OP_LOAD) && ok;
	end

	// bank b holds addresses with low bits b; big-endian byte order
	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [LANE_W-1:0] lane_j;
		logic [LANE_W-1:0] shift_k;
		logic              active;
		logic              carry;
		logic [31:0]       row_full;

		assign lane_j   = LANE_W'(LANE_W'(b) - item_s1.off[LANE_W-1:0]);
		assign active   = {1'b0, lane_j} < item_s1.cnt;
		assign shift_k  = LANE_W'(item_s1.cnt[LANE_W-1:0] - 3'd1 - lane_j);
		assign carry    = LANE_W'(b) < item_s1.off[LANE_W-1:0];
		assign row_full = 32'(item_s1.off[OFF_W-1:LANE_W]) + 32'(carry);

		assign bank_row[b]   = row_full[ROW_W-1:0];
		assign bank_wdata[b] = store_v[int'(shift_k) * BYTE_W +: BYTE_W];
		assign bank_we[b]    = adv && valid_s1 && is_store && ok && active;

		bmrm_ram #(.WIDTH(BYTE_W), .DEPTH(ROWS)) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_row[b]),
			.wdata (bank_wdata[b]),
			.re    (mem_re),
			.raddr (bank_row[b]),
			.rdata (bank_rdata[b])
		);
	end

	// gather loaded bytes: result byte k comes from access byte cnt-1-k
	always_comb begin
		logic [LANE_W-1:0] j;
		logic [LANE_W-1:0] sel;
		ld_val = '0;
		for (int k = 0; k < LANES; k++) begin
			j   = LANE_W'(cnt_s2[LANE_W-1:0] - 3'd1 - LANE_W'(k));
			sel = LANE_W'(lane0_s2 + j);
			if (CNT_W'(k) < cnt_s2) begin
				ld_val[k * BYTE_W +: BYTE_W] = bank_rdata[sel];
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1       <= head;
			op_s2         <= item_s1.op;
			status_s2     <= status_val;
			pval_s2       <= pval_val;
			alu_s2        <= alu_val;
			wr_s2         <= ok && (item_s1.op inside {OP_LOAD, OP_ADD, OP_SUB});
			rd_s2         <= ridx(item_s1.rd);
			lane0_s2      <= item_s1.off[LANE_W-1:0];
			cnt_s2        <= item_s1.cnt;
			status_q      <= status_s2;
			print_value_q <= pval_s2;
			lw_addr_q     <= rd_s2;
			lw_data_q     <= rf_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			lw_en_q     <= 1'b0;
			limit_q     <= '0;
			reg_valid_q <= '0;
		end else begin
			if (adv) begin
				valid_s1    <= head_valid;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
				lw_en_q     <= rf_we;
				if (valid_s1 && (item_s1.op == OP_ALLOC)) begin
					limit_q <= (item_s1.abytes > ABYTES_W'(LIM_CAP)) ?
						LIMIT_W'(LIM_CAP) : LIMIT_W'(item_s1.abytes);
				end
			end
			if (rf_we) begin
				reg_valid_q[rd_s2] <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign print_value = print_value_q;

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_PRINTED)) |-> (print_value_q == '0))
		else $error("print value set on non-print result");

	a_bank_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((|bank_we) && mem_re))
		else $error("byte banks written and read by one instruction");

	a_limit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q <= LIMIT_W'(LIM_CAP))
		else $error("memory limit above capacity");

	a_rf_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (status_s2 == ST_DONE))
		else $error("register write from a flagged instruction");

endmodule

@@ design/byte_memory_register_machine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_memory_register_machine_top: register machine with byte memory
// Runs one instruction per beat against a 64-bit register file and a
// byte-addressed memory; every instruction returns one status beat.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_stall   | opcode, regs, offset, count, imm, alloc
//   out     | out_valid / out_stall | status, print_value
//
// One instruction per cycle sustained while out_stall is not holding a result beat; an
// accepted instruction passes the queue, operand/memory stage s1, gather/writeback stage s2 and the result register.
// Loads forward into the next instruction without a bubble.
// Reset clears registers to zero and the memory limit to zero; no sweep.
// in_stall rises when the four-entry queue is full; out_stall freezes the
// whole execution pipeline while a result beat is held, and the queue then absorbs up to four beats.
// ----------------------------------------------------------------------------
module byte_memory_register_machine_top #(
	parameter int MEM_BYTES = 4096,
	parameter int NUM_REGS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bmrm_pkg::OPC_W-1:0]         opcode,
	input  logic [bmrm_pkg::REG_W-1:0]         dest_reg,
	input  logic [bmrm_pkg::REG_W-1:0]         src_reg_a,
	input  logic [bmrm_pkg::REG_W-1:0]         src_reg_b,
	input  logic [bmrm_pkg::OFF_W-1:0]         byte_offset,
	input  logic [bmrm_pkg::CNT_W-1:0]         byte_count,
	input  logic signed [bmrm_pkg::DATA_W-1:0] immediate,
	input  logic [bmrm_pkg::ABYTES_W-1:0]      alloc_bytes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bmrm_pkg::STATUS_W-1:0]      status,
	output logic signed [bmrm_pkg::DATA_W-1:0] print_value
);

	import bmrm_pkg::*;

	logic  head_valid;
	item_t head;
	logic  pop;

	bmrm_front #(.NUM_REGS(NUM_REGS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.dest_reg    (dest_reg),
		.src_reg_a   (src_reg_a),
		.src_reg_b   (src_reg_b),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.immediate   (immediate),
		.alloc_bytes (alloc_bytes),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	bmrm_back #(.MEM_BYTES(MEM_BYTES), .NUM_REGS(NUM_REGS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.print_value (print_value)
	);

endmodule

@@ dv/tb_byte_memory_register_machine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_memory_register_machine_top: testbench for the register machine
// Directed and random instruction streams are fed through a clocked driver.
// A cycle-free model of the register file, the byte memory and the limit
// predicts every status beat, and a clocked monitor checks each beat in order.
// ----------------------------------------------------------------------------
module tb_byte_memory_register_machine_top;
	import bmrm_pkg::*;

	localparam int MEM_BYTES   = 4096;
	localparam int NUM_REGS    = 16;
	localparam int REPORT_MAX  = 100;
	localparam int DRAIN_LIMIT = 100000;

	typedef struct {
		logic [OPC_W-1:0]    op;
		logic [REG_W-1:0]    rd;
		logic [REG_W-1:0]    ra;
		logic [REG_W-1:0]    rb;
		logic [OFF_W-1:0]    off;
		logic [CNT_W-1:0]    cnt;
		logic [DATA_W-1:0]   imm;
		logic [ABYTES_W-1:0] abytes;
	} instr_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   value;
	} outcome_t;

	typedef struct {
		int off;
		int cnt;
	} span_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [OPC_W-1:0]           opcode = OP_NOP;
	logic [REG_W-1:0]           dest_reg = '0;
	logic [REG_W-1:0]           src_reg_a = '0;
	logic [REG_W-1:0]           src_reg_b = '0;
	logic [OFF_W-1:0]           byte_offset = '0;
	logic [CNT_W-1:0]           byte_count = '0;
	logic signed [DATA_W-1:0]   immediate = '0;
	logic [ABYTES_W-1:0]        alloc_bytes = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic signed [DATA_W-1:0]   print_value;

	instr_t   instr_q[$];
	outcome_t expected_results[$];
	span_t    stored_spans[$];
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       mismatch_cnt = 0;
	bit       in_took = 1'b0;

	// machine state as seen by the predictor
	logic [DATA_W-1:0] mach_regs [NUM_REGS];
	logic [BYTE_W-1:0] mach_mem [MEM_BYTES];
	int                mach_limit = 0;

	// what the stimulus knows: usable limit and bytes already written
	bit gen_written [MEM_BYTES];
	int gen_limit = 0;

	byte_memory_register_machine_top #(
		.MEM_BYTES(MEM_BYTES),
		.NUM_REGS(NUM_REGS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.dest_reg(dest_reg),
		.src_reg_a(src_reg_a),
		.src_reg_b(src_reg_b),
		.byte_offset(byte_offset),
		.byte_count(byte_count),
		.immediate(immediate),
		.alloc_bytes(alloc_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.print_value(print_value)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		if (mismatch_cnt < REPORT_MAX) begin
			$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatch_cnt++;
	endtask

	function automatic logic [STATUS_W-1:0] access_status(logic [OFF_W-1:0] off,
			logic [CNT_W-1:0] cnt);
		if (cnt > MAX_BYTES) return ST_BAD;
		if (int'(off) + int'(cnt) > mach_limit) return ST_BOUNDS;
		return ST_DONE;
	endfunction

	function automatic outcome_t execute_instr(instr_t it);
		outcome_t          res;
		logic [DATA_W-1:0] word;
		int                shift;
		res.status = ST_DONE;
		res.value = '0;
		word = it.imm;
		case (it.op)
			OP_ALLOC: begin
				mach_limit = (int'(it.abytes) > MEM_BYTES) ? MEM_BYTES : int'(it.abytes);
			end
			OP_STORE_IMM, OP_STORE_REG: begin
				if (it.op == OP_STORE_REG && int'(it.ra) >= NUM_REGS) begin
					res.status = ST_BAD;
				end else begin
					if (it.op == OP_STORE_REG) begin
						word = mach_regs[it.ra];
					end
					res.status = access_status(it.off, it.cnt);
					if (res.status == ST_DONE) begin
						// most significant byte goes to the lowest address
						for (int i = 0; i < int'(it.cnt); i++) begin
							shift = (int'(it.cnt) - 1 - i) * 8;
							mach_mem[int'(it.off) + i] = BYTE_W'(word >> shift);
						end
					end
				end
			end
			OP_LOAD: begin
				if (int'(it.rd) >= NUM_REGS) begin
					res.status = ST_BAD;
				end else begin
					res.status = access_status(it.off, it.cnt);
					if (res.status == ST_DONE) begin
						word = '0;
						for (int i = 0; i < int'(it.cnt); i++) begin
							word = {word[DATA_W-BYTE_W-1:0], mach_mem[int'(it.off) + i]};
						end
						mach_regs[it.rd] = word;
					end
				end
			end
			OP_ADD, OP_SUB: begin
				if (int'(it.rd) >= NUM_REGS || int'(it.ra) >= NUM_REGS ||
						int'(it.rb) >= NUM_REGS) begin
					res.status = ST_BAD;
				end else if (it.op == OP_ADD) begin
					mach_regs[it.rd] = mach_regs[it.ra] + mach_regs[it.rb];
				end else begin
					mach_regs[it.rd] = mach_regs[it.ra] - mach_regs[it.rb];
				end
			end
			OP_PRINT: begin
				if (int'(it.rd) >= NUM_REGS) begin
					res.status = ST_BAD;
				end else begin
					res.status = ST_PRINTED;
					res.value = mach_regs[it.rd];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic queue_instr(logic [OPC_W-1:0] op, logic [REG_W-1:0] rd, ra, rb,
			logic [OFF_W-1:0] off, logic [CNT_W-1:0] cnt, logic [DATA_W-1:0] imm,
			logic [ABYTES_W-1:0] abytes);
		instr_t it;
		span_t  sp;
		it.op = op;
		it.rd = rd;
		it.ra = ra;
		it.rb = rb;
		it.off = off;
		it.cnt = cnt;
		it.imm = imm;
		it.abytes = abytes;
		instr_q.push_back(it);
		if (op == OP_ALLOC) begin
			gen_limit = (int'(abytes) > MEM_BYTES) ? MEM_BYTES : int'(abytes);
		end
		if ((op == OP_STORE_IMM || (op == OP_STORE_REG && int'(ra) < NUM_REGS)) &&
				cnt != 0 && cnt <= MAX_BYTES && int'(off) + int'(cnt) <= gen_limit) begin
			for (int i = 0; i < int'(cnt); i++) begin
				gen_written[int'(off) + i] = 1'b1;
			end
			sp.off = off;
			sp.cnt = cnt;
			stored_spans.push_back(sp);
			if (stored_spans.size() > 32) begin
				void'(stored_spans.pop_front());
			end
		end
	endtask

	// true when a load of this span passes its checks and touches only written bytes
	function automatic bit span_readable(int off, int cnt);
		if (cnt > 8 || off + cnt > gen_limit) return 1'b0;
		for (int i = 0; i < cnt; i++) begin
			if (!gen_written[off + i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [OFF_W-1:0] pick_offset(int cnt);
		int top;
		top = gen_limit - cnt;
		if (top < 0) return OFF_W'($urandom);
		if (top > MEM_BYTES - 1) top = MEM_BYTES - 1;
		// keep most accesses in a small window so loads find stored data
		if (top > 63 && $urandom_range(9) < 7) top = 63;
		return OFF_W'($urandom_range(top));
	endfunction

	task automatic gen_random_instr();
		logic [OPC_W-1:0]    op;
		logic [REG_W-1:0]    rd;
		logic [REG_W-1:0]    ra;
		logic [REG_W-1:0]    rb;
		logic [OFF_W-1:0]    off;
		logic [CNT_W-1:0]    cnt;
		logic [DATA_W-1:0]   imm;
		logic [ABYTES_W-1:0] abytes;
		int                  pick;
		int                  tries;
		bit                  found;
		span_t               sp;
		pick = $urandom_range(99);
		rd = REG_W'($urandom);
		ra = REG_W'($urandom);
		rb = REG_W'($urandom);
		off = OFF_W'($urandom);
		cnt = CNT_W'($urandom);
		imm = {$urandom, $urandom};
		abytes = ABYTES_W'($urandom);
		case ($urandom_range(15))
			0: imm = '0;
			1: imm = '1;
			2: imm = {1'b1, {(DATA_W-1){1'b0}}};
			default: begin
			end
		endcase
		if (pick < 4) begin
			op = OP_ALLOC;
			case ($urandom_range(9))
				0: abytes = ABYTES_W'($urandom_range(15));
				1: abytes = ABYTES_W'($urandom_range(8191, 4097));
				2: begin
				end
				default: abytes = ABYTES_W'($urandom_range(4096, 64));
			endcase
		end else if (pick < 8) begin
			op = OP_NOP;
		end else if (pick < 45) begin
			op = (pick < 30) ? OP_STORE_IMM : OP_STORE_REG;
			if ($urandom_range(9) != 0) begin
				cnt = CNT_W'($urandom_range(8));
				off = pick_offset(cnt);
			end
		end else if (pick < 70) begin
			op = OP_LOAD;
			found = 1'b0;
			tries = ($urandom_range(9) == 0) ? 16 : 0;
			while (tries < 16 && !found) begin
				if (stored_spans.size() != 0 && $urandom_range(1) == 1) begin
					sp = stored_spans[$urandom_range(stored_spans.size() - 1)];
					off = OFF_W'(sp.off + $urandom_range(sp.cnt - 1));
				end else begin
					off = OFF_W'($urandom_range(63));
				end
				cnt = CNT_W'($urandom_range(8));
				found = span_readable(int'(off), int'(cnt));
				tries++;
			end
			// otherwise issue a load that is flagged or reads nothing
			if (!found) begin
				case ($urandom_range(2))
					0: cnt = CNT_W'($urandom_range(15, 9));
					1: begin
						// run past the end of memory
						off = OFF_W'($urandom_range(MEM_BYTES - 1, MEM_BYTES - 7));
						cnt = CNT_W'($urandom_range(8, MEM_BYTES + 1 - int'(off)));
					end
					default: begin
						cnt = '0;
						off = OFF_W'($urandom_range(gen_limit > MEM_BYTES - 1 ?
							MEM_BYTES - 1 : gen_limit));
					end
				endcase
			end
		end else if (pick < 80) begin
			op = OP_ADD;
		end else if (pick < 90) begin
			op = OP_SUB;
		end else begin
			op = OP_PRINT;
		end
		queue_instr(op, rd, ra, rb, off, cnt, imm, abytes);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((instr_q.size() != 0 || in_valid || expected_results.size() != 0) &&
				guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// monitor: predict on each accepted instruction, check each accepted result
	always @(posedge clk) begin
		instr_t   seen;
		outcome_t want;
		in_took = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_took = 1'b1;
				seen.op = opcode;
				seen.rd = dest_reg;
				seen.ra = src_reg_a;
				seen.rb = src_reg_b;
				seen.off = byte_offset;
				seen.cnt = byte_count;
				seen.imm = immediate;
				seen.abytes = alloc_bytes;
				expected_results.push_back(execute_instr(seen));
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", print_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
					end
					if (print_value !== want.value) begin
						report_mismatch("print_value", print_value, want.value);
					end
				end
			end
		end
	end

	// driver: hold the beat until taken, then advance or idle
	always @(negedge clk) begin
		instr_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if (!in_valid || in_took) begin
				if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = instr_q.pop_front();
					opcode <= nxt.op;
					dest_reg <= nxt.rd;
					src_reg_a <= nxt.ra;
					src_reg_b <= nxt.rb;
					byte_offset <= nxt.off;
					byte_count <= nxt.cnt;
					immediate <= nxt.imm;
					alloc_bytes <= nxt.abytes;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		outcome_t want;
		foreach (mach_regs[i]) begin
			mach_regs[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 27;
		recv_idle_pct = 85;
		// registers read zero and the limit is zero after reset
		queue_instr(OP_PRINT, 4'd0, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_LOAD, 4'd1, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd0, 4'd1, 64'd5, 13'd0);
		// oversized alloc saturates
		queue_instr(OP_ALLOC, 4'd0, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd8191);
		queue_instr(OP_NOP, 4'd15, 4'd15, 4'd15, 12'd4095, 4'd15, '1, 13'd8191);
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd0, 4'd8,
			64'h8123_4567_89ab_cdef, 13'd0);
		queue_instr(OP_LOAD, 4'd1, 4'd0, 4'd0, 12'd0, 4'd8, 64'd0, 13'd0);
		queue_instr(OP_PRINT, 4'd1, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		// access that ends exactly at the limit
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd4088, 4'd8, '1, 13'd0);
		queue_instr(OP_LOAD, 4'd2, 4'd0, 4'd0, 12'd4088, 4'd8, 64'd0, 13'd0);
		// a single 0xff byte must come back unsigned
		queue_instr(OP_LOAD, 4'd3, 4'd0, 4'd0, 12'd4095, 4'd1, 64'd0, 13'd0);
		queue_instr(OP_LOAD, 4'd4, 4'd0, 4'd0, 12'd4090, 4'd8, 64'd0, 13'd0);
		// sizes above eight are flagged on stores and loads
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd100, 4'd9, 64'd1, 13'd0);
		queue_instr(OP_LOAD, 4'd5, 4'd0, 4'd0, 12'd0, 4'd15, 64'd0, 13'd0);
		// zero-byte load clears the register, zero-byte store writes nothing
		queue_instr(OP_LOAD, 4'd1, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd200, 4'd0, '1, 13'd0);
		queue_instr(OP_PRINT, 4'd1, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		// wrapping add and sub
		queue_instr(OP_ADD, 4'd7, 4'd2, 4'd3, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_SUB, 4'd8, 4'd0, 4'd3, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_PRINT, 4'd7, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_STORE_REG, 4'd0, 4'd8, 4'd0, 12'd16, 4'd3, 64'd0, 13'd0);
		queue_instr(OP_LOAD, 4'd9, 4'd0, 4'd0, 12'd16, 4'd3, 64'd0, 13'd0);
		queue_instr(OP_ADD, 4'd15, 4'd15, 4'd9, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_PRINT, 4'd15, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		// with no memory a zero-byte access at offset zero is still in bounds
		queue_instr(OP_ALLOC, 4'd0, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_STORE_IMM, 4'd0, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd0);
		queue_instr(OP_ALLOC, 4'd0, 4'd0, 4'd0, 12'd0, 4'd0, 64'd0, 13'd4096);
		repeat (530) gen_random_instr();
		wait_drained();

		send_idle_pct = 85;
		recv_idle_pct = 27;
		repeat (530) gen_random_instr();
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (540) gen_random_instr();
		wait_drained();

		repeat (16) @(posedge clk);
		while (expected_results.size() != 0) begin
			want = expected_results.pop_front();
			report_mismatch("missing result beat", '0, want.value);
		end
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
